// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk while out of reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk while out of reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/d2q9_pkg.sv =====
`timescale 1ns / 1ps

package d2q9_pkg;

    localparam int NDIR       = 9;
    // one quotient bit per divider stage, velocity magnitude below 2^31
    localparam int DIV_STAGES = 31;
    // two sum stages, the divider, then nine equilibrium/relax stages
    localparam int LATENCY    = 2 + DIV_STAGES + 9;

    localparam logic [30:0] INV_TAU_RESET = 31'd1789569707;
    // floor(2^36 / 9)
    localparam logic [32:0] DIV9_RECIP    = 33'd7635497415;

    typedef logic signed [31:0] word_t;

    typedef enum logic [1:0] {
        W_REST,
        W_AXIS,
        W_DIAG
    } weight_t;

    localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    localparam weight_t DIR_W [NDIR] = '{W_REST, W_AXIS, W_AXIS, W_AXIS, W_AXIS,
                                         W_DIAG, W_DIAG, W_DIAG, W_DIAG};

    typedef struct packed {
        logic [NDIR-1:0][31:0] f;
        logic                  solid;
        logic [31:0]           rho;
        logic [31:0]           ux;
        logic [31:0]           uy;
    } node_t;

    typedef struct packed {
        logic rho_pos;
        logic ovf_x;
        logic ovf_y;
        logic neg_x;
        logic neg_y;
    } vsel_t;

    function automatic word_t sat32(input logic signed [63:0] v);
        word_t r;
        priority if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(input word_t v);
        logic [31:0] r;
        if (v[31])
        begin
            r = 32'(-33'(v));
        end
        else
        begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

// ===== hdl/d2q9_bgk_collision_node_top.sv =====
`timescale 1ns / 1ps

// D2Q9 BGK collision, one lattice node per transaction.
// node channel: node_valid/node_stall with the nine distributions f_* and
// the solid flag. result channel: result_valid/result_stall with the nine
// post-collision distributions out_*, density, vel_x and vel_y.
// the user must write inv_tau through inv_tau_we/inv_tau_wdata only while
// idle; the block does not enforce it. accept to result_valid: two sum
// stages, 31 stages of the bit-per-stage velocity divider, nine equilibrium
// and relaxation stages. throughput is one node per cycle unless stalled.
// the whole pipeline advances together; while a result is held by
// result_stall every stage holds and node_stall is raised, so nothing is
// lost or repeated. bubbles travel as cleared valid bits.
// reset clears all valid bits and loads inv_tau with about 1/0.6.
// solid nodes come out unchanged with zero density and velocity.
module d2q9_bgk_collision_node_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        inv_tau_we,
    input  logic [30:0] inv_tau_wdata,
    input  logic        node_valid,
    output logic        node_stall,
    input  logic [31:0] f_rest,
    input  logic [31:0] f_east,
    input  logic [31:0] f_north,
    input  logic [31:0] f_west,
    input  logic [31:0] f_south,
    input  logic [31:0] f_northeast,
    input  logic [31:0] f_northwest,
    input  logic [31:0] f_southwest,
    input  logic [31:0] f_southeast,
    input  logic        solid,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] out_rest,
    output logic [31:0] out_east,
    output logic [31:0] out_north,
    output logic [31:0] out_west,
    output logic [31:0] out_south,
    output logic [31:0] out_northeast,
    output logic [31:0] out_northwest,
    output logic [31:0] out_southwest,
    output logic [31:0] out_southeast,
    output logic [31:0] density,
    output logic [31:0] vel_x,
    output logic [31:0] vel_y
);

    localparam int ND  = d2q9_pkg::NDIR;
    localparam int LAT = d2q9_pkg::LATENCY;
    localparam int NS  = d2q9_pkg::DIV_STAGES;

    localparam logic signed [39:0] POLY_ONE = 40'sd1 <<< 30;
    localparam logic signed [39:0] POLY_MAX = (40'sd1 <<< 33) - 40'sd1;
    localparam logic signed [39:0] POLY_MIN = -(40'sd1 <<< 33);
    localparam logic signed [36:0] DIFF_MAX = (37'sd1 <<< 32) - 37'sd1;
    localparam logic signed [36:0] DIFF_MIN = -DIFF_MAX;

    // ---------------- control ----------------
    logic [30:0]    inv_tau_reg;
    logic [LAT-1:0] vld_reg;
    logic           ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_tau_reg <= d2q9_pkg::INV_TAU_RESET;
        end
        else if (inv_tau_we)
        begin
            inv_tau_reg <= inv_tau_wdata;
        end
    end

    assign ce           = !(vld_reg[LAT-1] && result_stall);
    assign node_stall   = !ce;
    assign result_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[LAT-2:0], node_valid};
        end
    end

    // ---------------- stage 1: partial sums ----------------
    d2q9_pkg::word_t    f_in [ND];
    d2q9_pkg::word_t    s1_f_reg [ND];
    logic               s1_solid_reg;
    logic signed [35:0] s1_rho_a_reg, s1_rho_b_reg;
    logic signed [35:0] s1_jx_a_reg, s1_jx_b_reg;
    logic signed [35:0] s1_jy_a_reg, s1_jy_b_reg;

    assign f_in[0] = f_rest;
    assign f_in[1] = f_east;
    assign f_in[2] = f_north;
    assign f_in[3] = f_west;
    assign f_in[4] = f_south;
    assign f_in[5] = f_northeast;
    assign f_in[6] = f_northwest;
    assign f_in[7] = f_southwest;
    assign f_in[8] = f_southeast;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_f_reg     <= f_in;
            s1_solid_reg <= solid;
            s1_rho_a_reg <= 36'(f_in[0]) + 36'(f_in[1]) + 36'(f_in[2])
                            + 36'(f_in[3]) + 36'(f_in[4]);
            s1_rho_b_reg <= 36'(f_in[5]) + 36'(f_in[6]) + 36'(f_in[7]) + 36'(f_in[8]);
            s1_jx_a_reg  <= 36'(f_in[1]) - 36'(f_in[3]);
            s1_jx_b_reg  <= 36'(f_in[5]) - 36'(f_in[6]) - 36'(f_in[7]) + 36'(f_in[8]);
            s1_jy_a_reg  <= 36'(f_in[2]) - 36'(f_in[4]);
            s1_jy_b_reg  <= 36'(f_in[5]) + 36'(f_in[6]) - 36'(f_in[7]) - 36'(f_in[8]);
        end
    end

    // ---------------- stage 2: moments and divider setup ----------------
    d2q9_pkg::node_t s2_node_reg, s2_node_next;
    d2q9_pkg::vsel_t s2_vsel_reg, s2_vsel_next;
    logic [31:0]     s2_absx_reg, s2_absx_next;
    logic [31:0]     s2_absy_reg, s2_absy_next;
    d2q9_pkg::word_t rho_s, jx_s, jy_s;

    always_comb
    begin
        rho_s = d2q9_pkg::sat32(64'(s1_rho_a_reg + s1_rho_b_reg));
        jx_s  = d2q9_pkg::sat32(64'(s1_jx_a_reg + s1_jx_b_reg));
        jy_s  = d2q9_pkg::sat32(64'(s1_jy_a_reg + s1_jy_b_reg));
        for (int i = 0; i < ND; i++)
        begin
            s2_node_next.f[i] = s1_f_reg[i];
        end
        s2_node_next.solid = s1_solid_reg;
        s2_node_next.rho   = rho_s;
        // momentum kept in the velocity slots until the quotient is ready
        s2_node_next.ux    = jx_s;
        s2_node_next.uy    = jy_s;
        s2_absx_next = d2q9_pkg::abs32(jx_s);
        s2_absy_next = d2q9_pkg::abs32(jy_s);
        s2_vsel_next.rho_pos = !rho_s[31] && (rho_s != 32'sd0);
        // quotient of at least 2^31 when |j| >= 2*rho
        s2_vsel_next.ovf_x = {1'b0, s2_absx_next} >= {rho_s, 1'b0};
        s2_vsel_next.ovf_y = {1'b0, s2_absy_next} >= {rho_s, 1'b0};
        s2_vsel_next.neg_x = jx_s[31];
        s2_vsel_next.neg_y = jy_s[31];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s2_node_reg <= s2_node_next;
            s2_vsel_reg <= s2_vsel_next;
            s2_absx_reg <= s2_absx_next;
            s2_absy_reg <= s2_absy_next;
        end
    end

    // ---------------- velocity dividers ----------------
    logic [NS-1:0]   qx, qy;
    d2q9_pkg::node_t dn_node_reg [NS];
    d2q9_pkg::vsel_t dn_vsel_reg [NS];

    d2q9_div u_div_x
    (
        .clk (clk),
        .ce  (ce),
        .num (s2_absx_reg),
        .den (s2_node_reg.rho),
        .quo (qx)
    );

    d2q9_div u_div_y
    (
        .clk (clk),
        .ce  (ce),
        .num (s2_absy_reg),
        .den (s2_node_reg.rho),
        .quo (qy)
    );

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dn_node_reg[0] <= s2_node_reg;
            dn_vsel_reg[0] <= s2_vsel_reg;
            for (int i = 1; i < NS; i++)
            begin
                dn_node_reg[i] <= dn_node_reg[i-1];
                dn_vsel_reg[i] <= dn_vsel_reg[i-1];
            end
        end
    end

    // ---------------- stage D: velocity, weight estimates ----------------
    function automatic d2q9_pkg::word_t vel_of(input logic rho_pos, input logic ovf,
                                               input logic neg, input logic [31:0] j,
                                               input logic [NS-1:0] q);
        d2q9_pkg::word_t r;
        priority if (!rho_pos)
        begin
            r = j;
        end
        else if (ovf)
        begin
            r = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else if (neg)
        begin
            r = -$signed(32'(q));
        end
        else
        begin
            r = $signed(32'(q));
        end
        return r;
    endfunction

    d2q9_pkg::node_t d_node_reg, d_node_next;
    logic [33:0]     d_m_reg [3];
    logic [33:0]     d_m_next [3];
    logic [30:0]     d_est_reg [3];
    logic [30:0]     d_est_next [3];
    logic [66:0]     d_prod [3];
    logic [31:0]     abs_rho;

    always_comb
    begin
        d_node_next    = dn_node_reg[NS-1];
        d_node_next.ux = vel_of(dn_vsel_reg[NS-1].rho_pos, dn_vsel_reg[NS-1].ovf_x,
                                dn_vsel_reg[NS-1].neg_x, dn_node_reg[NS-1].ux, qx);
        d_node_next.uy = vel_of(dn_vsel_reg[NS-1].rho_pos, dn_vsel_reg[NS-1].ovf_y,
                                dn_vsel_reg[NS-1].neg_y, dn_node_reg[NS-1].uy, qy);
        abs_rho = d2q9_pkg::abs32($signed(dn_node_reg[NS-1].rho));
        // rest weight 16/36 -> 4|rho|/9, axis 4/36 -> |rho|/9, diagonal -> (|rho|/4)/9
        d_m_next[d2q9_pkg::W_REST] = {abs_rho, 2'b00};
        d_m_next[d2q9_pkg::W_AXIS] = 34'(abs_rho);
        d_m_next[d2q9_pkg::W_DIAG] = 34'(abs_rho[31:2]);
        for (int k = 0; k < 3; k++)
        begin
            d_prod[k]     = 67'(d_m_next[k]) * 67'(d2q9_pkg::DIV9_RECIP);
            d_est_next[k] = d_prod[k][66:36];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            d_node_reg <= d_node_next;
            d_m_reg    <= d_m_next;
            d_est_reg  <= d_est_next;
        end
    end

    // ---------------- stage E: squares, projections, weights ----------------
    d2q9_pkg::node_t    e_node_reg;
    logic signed [63:0] e_uxx_reg, e_uyy_reg;
    d2q9_pkg::word_t    e_cu_reg [ND];
    d2q9_pkg::word_t    e_cu_next [ND];
    d2q9_pkg::word_t    e_wr_reg [3];
    d2q9_pkg::word_t    e_wr_next [3];
    logic [34:0]        nine_est [3];
    logic [34:0]        rem9 [3];
    logic [31:0]        q9 [3];
    logic signed [33:0] cx, cy;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            // estimate is exact or one low
            nine_est[k] = 35'({d_est_reg[k], 3'b000}) + 35'(d_est_reg[k]);
            rem9[k]     = 35'(d_m_reg[k]) - nine_est[k];
            q9[k]       = 32'(d_est_reg[k]) + 32'(rem9[k] >= 35'd9);
            e_wr_next[k] = d_node_reg.rho[31] ? -$signed(q9[k]) : $signed(q9[k]);
        end
        for (int i = 0; i < ND; i++)
        begin
            priority if (d2q9_pkg::DIR_X[i] == 1)
            begin
                cx = 34'($signed(d_node_reg.ux));
            end
            else if (d2q9_pkg::DIR_X[i] == -1)
            begin
                cx = -34'($signed(d_node_reg.ux));
            end
            else
            begin
                cx = '0;
            end
            priority if (d2q9_pkg::DIR_Y[i] == 1)
            begin
                cy = 34'($signed(d_node_reg.uy));
            end
            else if (d2q9_pkg::DIR_Y[i] == -1)
            begin
                cy = -34'($signed(d_node_reg.uy));
            end
            else
            begin
                cy = '0;
            end
            e_cu_next[i] = d2q9_pkg::sat32(64'(cx + cy));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            e_node_reg <= d_node_reg;
            e_uxx_reg  <= 64'($signed(d_node_reg.ux)) * 64'($signed(d_node_reg.ux));
            e_uyy_reg  <= 64'($signed(d_node_reg.uy)) * 64'($signed(d_node_reg.uy));
            e_cu_reg   <= e_cu_next;
            e_wr_reg   <= e_wr_next;
        end
    end

    // ---------------- stage F: |u|^2 and cu^2 ----------------
    d2q9_pkg::node_t    f_node_reg;
    logic [33:0]        f_u2_reg;
    logic [32:0]        f_cusq_reg [ND];
    logic [32:0]        f_cusq_next [ND];
    d2q9_pkg::word_t    f_cu_reg [ND];
    d2q9_pkg::word_t    f_wr_reg [3];
    logic [63:0]        usq;
    logic signed [63:0] cu_sq [ND];

    always_comb
    begin
        usq = $unsigned(e_uxx_reg) + $unsigned(e_uyy_reg);
        for (int i = 0; i < ND; i++)
        begin
            cu_sq[i]       = 64'(e_cu_reg[i]) * 64'(e_cu_reg[i]);
            f_cusq_next[i] = cu_sq[i][62:30];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            f_node_reg <= e_node_reg;
            f_u2_reg   <= usq[63:30];
            f_cusq_reg <= f_cusq_next;
            f_cu_reg   <= e_cu_reg;
            f_wr_reg   <= e_wr_reg;
        end
    end

    // ---------------- stage G: equilibrium bracket ----------------
    d2q9_pkg::node_t    g_node_reg;
    logic signed [33:0] g_poly_reg [ND];
    logic signed [33:0] g_poly_next [ND];
    d2q9_pkg::word_t    g_wr_reg [3];
    logic [39:0]        h_cu2 [ND];
    logic [39:0]        h_u2;
    logic signed [39:0] poly [ND];

    always_comb
    begin
        h_u2 = (40'(f_u2_reg) * 40'd3) >> 1;
        for (int i = 0; i < ND; i++)
        begin
            h_cu2[i] = (40'(f_cusq_reg[i]) * 40'd9) >> 1;
            poly[i]  = POLY_ONE + 40'(f_cu_reg[i]) * 40'sd3 + $signed(h_cu2[i])
                       - $signed(h_u2);
            priority if (poly[i] > POLY_MAX)
            begin
                g_poly_next[i] = 34'(POLY_MAX);
            end
            else if (poly[i] < POLY_MIN)
            begin
                g_poly_next[i] = 34'(POLY_MIN);
            end
            else
            begin
                g_poly_next[i] = 34'(poly[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            g_node_reg <= f_node_reg;
            g_poly_reg <= g_poly_next;
            g_wr_reg   <= f_wr_reg;
        end
    end

    // ---------------- stage H: weight times bracket ----------------
    d2q9_pkg::node_t    h_node_reg;
    logic signed [65:0] h_prod_reg [ND];
    logic signed [65:0] h_prod_next [ND];

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            h_prod_next[i] = 66'(g_wr_reg[d2q9_pkg::DIR_W[i]]) * 66'(g_poly_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            h_node_reg <= g_node_reg;
            h_prod_reg <= h_prod_next;
        end
    end

    // ---------------- stage I: equilibrium rescale ----------------
    d2q9_pkg::node_t    i_node_reg;
    logic signed [35:0] i_feq_reg [ND];
    logic signed [35:0] i_feq_next [ND];
    logic signed [65:0] h_bias [ND];

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            // round toward zero
            h_bias[i]     = h_prod_reg[i] + (h_prod_reg[i][65] ? 66'sd1073741823 : 66'sd0);
            i_feq_next[i] = 36'(h_bias[i] >>> 30);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            i_node_reg <= h_node_reg;
            i_feq_reg  <= i_feq_next;
        end
    end

    // ---------------- stage J: non-equilibrium part ----------------
    d2q9_pkg::node_t    j_node_reg;
    logic signed [32:0] j_diff_reg [ND];
    logic signed [32:0] j_diff_next [ND];
    logic signed [36:0] diff_w [ND];

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            diff_w[i] = 37'($signed(i_node_reg.f[i])) - 37'(i_feq_reg[i]);
            priority if (diff_w[i] > DIFF_MAX)
            begin
                j_diff_next[i] = 33'(DIFF_MAX);
            end
            else if (diff_w[i] < DIFF_MIN)
            begin
                j_diff_next[i] = 33'(DIFF_MIN);
            end
            else
            begin
                j_diff_next[i] = 33'(diff_w[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            j_node_reg <= i_node_reg;
            j_diff_reg <= j_diff_next;
        end
    end

    // ---------------- stage K: relaxation product ----------------
    d2q9_pkg::node_t    k_node_reg;
    logic signed [64:0] k_p_reg [ND];
    logic signed [64:0] k_p_next [ND];

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            k_p_next[i] = 65'($signed({1'b0, inv_tau_reg})) * 65'(j_diff_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            k_node_reg <= j_node_reg;
            k_p_reg    <= k_p_next;
        end
    end

    // ---------------- stage L: output register ----------------
    d2q9_pkg::word_t    l_out_reg [ND];
    d2q9_pkg::word_t    l_out_next [ND];
    logic [31:0]        l_rho_reg, l_ux_reg, l_uy_reg;
    logic               l_solid_reg;
    logic signed [64:0] k_bias [ND];
    logic signed [34:0] delta [ND];

    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            k_bias[i] = k_p_reg[i] + (k_p_reg[i][64] ? 65'sd1073741823 : 65'sd0);
            delta[i]  = 35'(k_bias[i] >>> 30);
            if (k_node_reg.solid)
            begin
                l_out_next[i] = $signed(k_node_reg.f[i]);
            end
            else
            begin
                l_out_next[i] = d2q9_pkg::sat32(64'($signed(k_node_reg.f[i])) - 64'(delta[i]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            l_out_reg   <= l_out_next;
            l_solid_reg <= k_node_reg.solid;
            l_rho_reg   <= k_node_reg.solid ? 32'd0 : k_node_reg.rho;
            l_ux_reg    <= k_node_reg.solid ? 32'd0 : k_node_reg.ux;
            l_uy_reg    <= k_node_reg.solid ? 32'd0 : k_node_reg.uy;
        end
    end

    assign out_rest      = l_out_reg[0];
    assign out_east      = l_out_reg[1];
    assign out_north     = l_out_reg[2];
    assign out_west      = l_out_reg[3];
    assign out_south     = l_out_reg[4];
    assign out_northeast = l_out_reg[5];
    assign out_northwest = l_out_reg[6];
    assign out_southwest = l_out_reg[7];
    assign out_southeast = l_out_reg[8];
    assign density       = l_rho_reg;
    assign vel_x         = l_ux_reg;
    assign vel_y         = l_uy_reg;

    // ---------------- assertions ----------------
`include "assert_macros.svh"

    `ASSERT_IMP(a_result_from_pipe, $rose(result_valid), $past(vld_reg[LAT-2]), "result without item in last stage")
    `ASSERT_IMP(a_solid_zero, result_valid && l_solid_reg, density == 32'd0 && vel_x == 32'd0 && vel_y == 32'd0, "solid node with nonzero moments")
    `ASSERT_NXT(a_tau_hold, !inv_tau_we, $stable(inv_tau_reg), "inv_tau changed without a write")

endmodule

// ===== hdl/d2q9_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage; num < 2*den is assumed
module d2q9_div
(
    input  logic                                 clk,
    input  logic                                 ce,
    input  logic [31:0]                          num,
    input  logic [31:0]                          den,
    output logic [d2q9_pkg::DIV_STAGES-1:0]      quo
);

    localparam int NS = d2q9_pkg::DIV_STAGES;

    logic [31:0]   rem_reg [NS];
    logic [31:0]   den_reg [NS];
    logic [NS-1:0] quo_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [32:0]   trial;
        logic [31:0]   den_in;
        logic [NS-1:0] q_in;
        logic          take;

        if (k == 0)
        begin : g_first
            // remainder num>>1 with the last dividend bit shifted in
            assign trial  = {1'b0, num};
            assign den_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign trial  = {rem_reg[k-1], 1'b0};
            assign den_in = den_reg[k-1];
            assign q_in   = quo_reg[k-1];
        end

        assign take = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[k] <= take ? 32'(trial - {1'b0, den_in}) : trial[31:0];
                den_reg[k] <= den_in;
                quo_reg[k] <= {q_in[NS-2:0], take};
            end
        end
    end

    assign quo = quo_reg[NS-1];

endmodule

// ===== verif/d2q9_bgk_collision_node_checker.sv =====
`timescale 1ns / 1ps

module d2q9_bgk_collision_node_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        inv_tau_we,
    input  logic [30:0] inv_tau_wdata,
    input  logic        node_valid,
    input  logic        node_stall,
    input  logic [31:0] f_rest,
    input  logic [31:0] f_east,
    input  logic [31:0] f_north,
    input  logic [31:0] f_west,
    input  logic [31:0] f_south,
    input  logic [31:0] f_northeast,
    input  logic [31:0] f_northwest,
    input  logic [31:0] f_southwest,
    input  logic [31:0] f_southeast,
    input  logic        solid,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] out_rest,
    input  logic [31:0] out_east,
    input  logic [31:0] out_north,
    input  logic [31:0] out_west,
    input  logic [31:0] out_south,
    input  logic [31:0] out_northeast,
    input  logic [31:0] out_northwest,
    input  logic [31:0] out_southwest,
    input  logic [31:0] out_southeast,
    input  logic [31:0] density,
    input  logic [31:0] vel_x,
    input  logic [31:0] vel_y,
    output int          errors,
    output int          pending
);

    typedef logic [11:0][31:0] collided_t;

    localparam longint Q30       = longint'(1) << 30;
    localparam longint WORD_MAX  = 64'sd2147483647;
    localparam longint WORD_MIN  = -64'sd2147483648;
    localparam longint WEIGHT36 [d2q9_pkg::NDIR] = '{16, 4, 4, 4, 4, 1, 1, 1, 1};
    localparam string  FIELD_NAME [12] = '{"out_rest", "out_east", "out_north",
        "out_west", "out_south", "out_northeast", "out_northwest",
        "out_southwest", "out_southeast", "density", "vel_x", "vel_y"};

    logic [30:0] relax_rate;
    collided_t   expected_nodes [$];

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        longint r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    function automatic longint sat_q30(input longint v);
        return clamp(v, WORD_MIN, WORD_MAX);
    endfunction

    function automatic collided_t collide_node(input logic [d2q9_pkg::NDIR-1:0][31:0] f_in,
                                               input logic is_solid,
                                               input logic [30:0] rate);
        collided_t  r;
        longint     f [d2q9_pkg::NDIR];
        longint     rho, jx, jy, ux, uy, u2, cu, cusq, poly, wr, feq, diff, dlt;
        logic [63:0] usq;
        int         i;
        rho = 0;
        jx = 0;
        jy = 0;
        for (i = 0; i < d2q9_pkg::NDIR; i++)
        begin
            f[i] = longint'($signed(f_in[i]));
        end
        if (is_solid)
        begin
            for (i = 0; i < d2q9_pkg::NDIR; i++)
            begin
                r[i] = f_in[i];
            end
            r[9] = '0;
            r[10] = '0;
            r[11] = '0;
            return r;
        end
        for (i = 0; i < d2q9_pkg::NDIR; i++)
        begin
            rho += f[i];
            jx += d2q9_pkg::DIR_X[i] * f[i];
            jy += d2q9_pkg::DIR_Y[i] * f[i];
        end
        rho = sat_q30(rho);
        jx = sat_q30(jx);
        jy = sat_q30(jy);
        if (rho > 0)
        begin
            ux = sat_q30((jx * Q30) / rho);
            uy = sat_q30((jy * Q30) / rho);
        end
        else
        begin
            // no division: momentum stands in for velocity
            ux = jx;
            uy = jy;
        end
        usq = 64'(ux * ux) + 64'(uy * uy);
        u2 = longint'(usq >> 30);
        for (i = 0; i < d2q9_pkg::NDIR; i++)
        begin
            cu = sat_q30(d2q9_pkg::DIR_X[i] * ux + d2q9_pkg::DIR_Y[i] * uy);
            cusq = longint'(64'(cu * cu) >> 30);
            poly = Q30 + 3 * cu + (9 * cusq) / 2 - (3 * u2) / 2;
            poly = clamp(poly, -(longint'(1) << 33), (longint'(1) << 33) - 1);
            wr = (rho * WEIGHT36[i]) / 36;
            feq = (wr * poly) / Q30;
            diff = clamp(f[i] - feq, -((longint'(1) << 32) - 1), (longint'(1) << 32) - 1);
            dlt = (longint'(rate) * diff) / Q30;
            r[i] = 32'(sat_q30(f[i] - dlt));
        end
        r[9] = 32'(rho);
        r[10] = 32'(ux);
        r[11] = 32'(uy);
        return r;
    endfunction

    assign pending = expected_nodes.size();

    always @(posedge clk or negedge rst_n)
    begin
        collided_t got;
        collided_t want;
        int        k;
        if (!rst_n)
        begin
            relax_rate <= d2q9_pkg::INV_TAU_RESET;
            errors <= 0;
            expected_nodes.delete();
        end
        else
        begin
            if (inv_tau_we)
            begin
                relax_rate <= inv_tau_wdata;
            end
            if (node_valid && !node_stall)
            begin
                expected_nodes.push_back(collide_node({f_southeast, f_southwest,
                    f_northwest, f_northeast, f_south, f_west, f_north, f_east,
                    f_rest}, solid, relax_rate));
            end
            if (result_valid && !result_stall)
            begin
                got = {vel_y, vel_x, density, out_southeast, out_southwest,
                       out_northwest, out_northeast, out_south, out_west,
                       out_north, out_east, out_rest};
                if (expected_nodes.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("%0t: result transaction with nothing expected", $realtime);
                    end
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_nodes.pop_front();
                    if (got != want)
                    begin
                        if (errors < 10)
                        begin
                            for (k = 0; k < 12; k++)
                            begin
                                if (got[k] != want[k])
                                begin
                                    $display("%0t: %s expected %h actual %h", $realtime,
                                             FIELD_NAME[k], want[k], got[k]);
                                end
                            end
                        end
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/d2q9_bgk_collision_node_top_tb.sv =====
`timescale 1ns / 1ps

module d2q9_bgk_collision_node_top_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        inv_tau_we = 1'b0;
    logic [30:0] inv_tau_wdata = '0;
    logic        node_valid = 1'b0;
    logic        node_stall;
    logic [d2q9_pkg::NDIR-1:0][31:0] f_drive = '0;
    logic        solid = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] out_rest, out_east, out_north, out_west, out_south;
    logic [31:0] out_northeast, out_northwest, out_southwest, out_southeast;
    logic [31:0] density, vel_x, vel_y;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          gap_chance = 0;

    always #4 clk = ~clk;

    d2q9_bgk_collision_node_top dut
    (
        .clk(clk), .rst_n(rst_n),
        .inv_tau_we(inv_tau_we), .inv_tau_wdata(inv_tau_wdata),
        .node_valid(node_valid), .node_stall(node_stall),
        .f_rest(f_drive[0]), .f_east(f_drive[1]), .f_north(f_drive[2]),
        .f_west(f_drive[3]), .f_south(f_drive[4]), .f_northeast(f_drive[5]),
        .f_northwest(f_drive[6]), .f_southwest(f_drive[7]), .f_southeast(f_drive[8]),
        .solid(solid),
        .result_valid(result_valid), .result_stall(result_stall),
        .out_rest(out_rest), .out_east(out_east), .out_north(out_north),
        .out_west(out_west), .out_south(out_south), .out_northeast(out_northeast),
        .out_northwest(out_northwest), .out_southwest(out_southwest),
        .out_southeast(out_southeast),
        .density(density), .vel_x(vel_x), .vel_y(vel_y)
    );

    d2q9_bgk_collision_node_checker checker_i
    (
        .clk(clk), .rst_n(rst_n),
        .inv_tau_we(inv_tau_we), .inv_tau_wdata(inv_tau_wdata),
        .node_valid(node_valid), .node_stall(node_stall),
        .f_rest(f_drive[0]), .f_east(f_drive[1]), .f_north(f_drive[2]),
        .f_west(f_drive[3]), .f_south(f_drive[4]), .f_northeast(f_drive[5]),
        .f_northwest(f_drive[6]), .f_southwest(f_drive[7]), .f_southeast(f_drive[8]),
        .solid(solid),
        .result_valid(result_valid), .result_stall(result_stall),
        .out_rest(out_rest), .out_east(out_east), .out_north(out_north),
        .out_west(out_west), .out_south(out_south), .out_northeast(out_northeast),
        .out_northwest(out_northwest), .out_southwest(out_southwest),
        .out_southeast(out_southeast),
        .density(density), .vel_x(vel_x), .vel_y(vel_y),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stall pattern: free, light and heavy stretches
    always @(negedge clk)
    begin
        int mode;
        mode = (cycles / 300) % 3;
        if (mode == 0)
        begin
            result_stall <= 1'b0;
        end
        else if (mode == 1)
        begin
            result_stall <= ($urandom_range(0, 99) < 25);
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < 70);
        end
    end

    task automatic send_node(input logic [d2q9_pkg::NDIR-1:0][31:0] fv, input logic is_solid);
        int gap;
        if ($urandom_range(0, 99) < gap_chance)
        begin
            node_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        node_valid <= 1'b1;
        f_drive <= fv;
        solid <= is_solid;
        forever
        begin
            @(posedge clk);
            if (!node_stall)
            begin
                break;
            end
        end
        @(negedge clk);
    endtask

    task automatic drain_nodes;
        node_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (d2q9_pkg::LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_rate(input logic [30:0] rate);
        drain_nodes();
        inv_tau_we <= 1'b1;
        inv_tau_wdata <= rate;
        @(negedge clk);
        inv_tau_we <= 1'b0;
        @(negedge clk);
    endtask

    // node near equilibrium at density rho with a small random flow
    function automatic logic [d2q9_pkg::NDIR-1:0][31:0] fluid_node(input int spread);
        logic [d2q9_pkg::NDIR-1:0][31:0] fv;
        longint rho;
        int     i;
        rho = longint'($urandom_range(0, 1 << 30)) + (1 << 29);
        for (i = 0; i < d2q9_pkg::NDIR; i++)
        begin
            fv[i] = 32'((i == 0) ? rho * 4 / 9 : ((i < 5) ? rho / 9 : rho / 36))
                    + 32'($signed($urandom_range(0, 2 * spread)) - spread);
        end
        return fv;
    endfunction

    task automatic directed_nodes;
        logic [d2q9_pkg::NDIR-1:0][31:0] fv;
        int i;
        send_node('0, 1'b0);
        send_node({d2q9_pkg::NDIR{32'h7FFFFFFF}}, 1'b0);
        send_node({d2q9_pkg::NDIR{32'h80000000}}, 1'b0);
        send_node({d2q9_pkg::NDIR{32'hFFFFFFFF}}, 1'b0);
        send_node({d2q9_pkg::NDIR{32'h00000001}}, 1'b0);
        send_node({d2q9_pkg::NDIR{32'h55555555}}, 1'b0);
        send_node({d2q9_pkg::NDIR{32'hAAAAAAAA}}, 1'b0);
        for (i = 0; i < d2q9_pkg::NDIR; i++)
        begin
            fv = '0;
            fv[i] = 32'h40000000;
            send_node(fv, 1'b0);
        end
        // zero density with momentum
        fv = '0;
        fv[1] = 32'h10000000;
        fv[3] = 32'hF0000000;
        fv[5] = 32'h08000000;
        fv[7] = 32'hF8000000;
        fv[2] = 32'h01000000;
        fv[4] = 32'hFF000000;
        send_node(fv, 1'b0);
        // negative density
        fv = {d2q9_pkg::NDIR{32'hF0000000}};
        fv[1] = 32'h00000100;
        send_node(fv, 1'b0);
        // tiny density, huge velocity saturates
        fv = '0;
        fv[1] = 32'h40000000;
        fv[3] = 32'hC0000001;
        send_node(fv, 1'b0);
        send_node(fluid_node(0), 1'b0);
        send_node({$urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom}, 1'b1);
        send_node({d2q9_pkg::NDIR{32'h80000000}}, 1'b1);
        send_node({d2q9_pkg::NDIR{32'h7FFFFFFF}}, 1'b1);
    endtask

    task automatic random_nodes(input int count);
        logic [d2q9_pkg::NDIR-1:0][31:0] fv;
        int n, pick, i;
        for (n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                gap_chance = (n % 80 == 0) ? 0 : $urandom_range(10, 60);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                fv = fluid_node(1 << $urandom_range(0, 27));
            end
            else if (pick < 80)
            begin
                for (i = 0; i < d2q9_pkg::NDIR; i++)
                begin
                    fv[i] = $urandom;
                end
            end
            else
            begin
                for (i = 0; i < d2q9_pkg::NDIR; i++)
                begin
                    fv[i] = 32'($signed($urandom) >>> $urandom_range(0, 31));
                end
            end
            send_node(fv, $urandom_range(0, 99) < 10);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        directed_nodes();
        random_nodes(60);
        write_rate('0);
        directed_nodes();
        random_nodes(60);
        write_rate(31'h7FFFFFFF);
        directed_nodes();
        random_nodes(60);
        write_rate(31'h40000000);
        random_nodes(120);
        write_rate(31'($urandom));
        random_nodes(120);
        write_rate(d2q9_pkg::INV_TAU_RESET);
        random_nodes(60);
        drain_nodes();
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/d2q9_pkg.sv
hdl/d2q9_div.sv
hdl/d2q9_bgk_collision_node_top.sv
verif/d2q9_bgk_collision_node_checker.sv
verif/d2q9_bgk_collision_node_top_tb.sv
